// ===== src/bba_pkg.sv =====
package bba_pkg;

  // Disk size; only the first 65536 blocks are addressable by a 16-bit number.
  localparam int BLOCKS = 65536;
  localparam int NBLK   = (BLOCKS < 65536) ? BLOCKS : 65536;

  // Map geometry: 64-bit map words, 32 words per summary group, 32 groups.
  localparam int WORD_W    = 64;
  localparam int BIT_W     = 6;
  localparam int MAP_WORDS = 1024;
  localparam int WADDR_W   = 10;
  localparam int GRP_N     = 32;
  localparam int GADDR_W   = 5;
  localparam int BLK_W     = 16;
  localparam int CNT_W     = 17;

  localparam logic [CNT_W-1:0] FREE_INIT = CNT_W'(NBLK - 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MARK    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOCHG = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALOC_L1,
    S_ALOC_MAP,
    S_UPD,
    S_PUT
  } state_t;

  // Map word after reset: block 0 and padding past the disk end are used.
  // Bit j of word w stands for block w*64+j.
  function automatic logic [WORD_W-1:0] word_init(input logic [WADDR_W-1:0] w);
    logic [WORD_W-1:0] v;
    int blk;
    v = '0;
    for (int j = 0; j < WORD_W; j++) begin
      blk  = int'(w) * WORD_W + j;
      v[j] = (blk >= NBLK) || (blk == 0);
    end
    return v;
  endfunction

  // A word is full after reset only when it lies wholly past the disk end.
  function automatic logic word_full_init(input logic [WADDR_W-1:0] w);
    return (int'(w) * WORD_W) >= NBLK;
  endfunction

  function automatic logic grp_full_init(input logic [GADDR_W-1:0] g);
    return (int'(g) * GRP_N * WORD_W) >= NBLK;
  endfunction

  // Lowest clear bit of a 32-bit summary word.
  function automatic logic [GADDR_W-1:0] first_zero32(input logic [GRP_N-1:0] v);
    logic [GADDR_W-1:0] idx;
    idx = '0;
    for (int i = GRP_N - 1; i >= 0; i--) begin
      if (!v[i]) begin
        idx = GADDR_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== src/bitmap_block_allocator_top.sv =====
// Channel  | Handshake             | Payload (lowest bit first)
// ---------+-----------------------+------------------------------------------------
// in_      | in_tvalid/in_tready   | tdata: block_number[15:0]; tuser: op[1:0]
// out_     | out_tvalid/out_tready | tdata: granted_block[15:0], free_count[32:16],
//          |                       |        zero fill [39:33]; tuser: status[1:0]
//
// One request at a time; a small sequencer drives one search/update unit.
// Allocate: accept + summary read, map word read, then commit, an order set by the two
// dependent registered reads. All other requests: accept, then commit or load.
// After reset a clearing pass writes all 1024 map words, in_tready low.
// A request is accepted while the previous result still waits in the output register;
// commit stalls only while that register is still occupied.
module bitmap_block_allocator_top
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // block_number[15:0]
  input  logic [1:0]  in_tuser,   // op[1:0]

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // granted_block[15:0], free_count[32:16], zeros
  output logic [1:0]  out_tuser   // status[1:0]
);

  // Map: one bit per block, 1 = used. Summary L1: one bit per map word, 1 = full.
  // Summary L2 (flops): one bit per group of 32 words, 1 = all full.
  logic [WORD_W-1:0] map_mem [MAP_WORDS];
  logic [GRP_N-1:0]  l1_mem  [GRP_N];
  logic [GRP_N-1:0]  l2_r;

  state_t              state_r, state_nxt;
  logic [WADDR_W-1:0]  clr_cnt_r;
  logic [CNT_W-1:0]    free_r;

  logic [WORD_W-1:0]   map_rd_r;
  logic [GRP_N-1:0]    l1_rd_r;
  logic [WADDR_W-1:0]  waddr_r, waddr_nxt;
  logic [BIT_W-1:0]    bit_r, bit_nxt;
  logic                rel_r, rel_nxt;
  status_t             res_r, res_nxt;

  logic                out_valid_r;
  logic [BLK_W-1:0]    out_grant_r;
  logic [CNT_W-1:0]    out_count_r;
  status_t             out_status_r;

  // Sequencer strobes
  logic                rd_map, rd_l1, commit, out_load, clr_we;
  logic [WADDR_W-1:0]  map_raddr;
  logic [GADDR_W-1:0]  l1_raddr;

  // Shared search/update unit
  logic                out_free, in_range, is_alloc, changed, old_bit, set_bit;
  logic [GADDR_W-1:0]  grp_sel, wsel;
  logic [2:0]          byte_sel, kk;
  logic [7:0]          byte_v;
  logic [BIT_W-1:0]    pos;
  logic [WORD_W-1:0]   map_new;
  logic [GRP_N-1:0]    l1_new, l1_init;
  logic [BLK_W-1:0]    grant;
  logic [CNT_W-1:0]    count_new;

  assign out_free = !out_valid_r || out_tready;
  assign in_range = {1'b0, in_tdata} < CNT_W'(NBLK);
  assign grp_sel  = first_zero32(l2_r);
  assign wsel     = first_zero32(l1_rd_r);
  assign clr_we   = (state_r == S_CLEAR);
  assign is_alloc = (state_r == S_ALOC_MAP);

  // Allocate: first byte not full, then its free bit of highest block number.
  always_comb begin
    byte_sel = '0;
    for (int b = 7; b >= 0; b--) begin
      if (map_rd_r[8*b +: 8] != 8'hFF) begin
        byte_sel = 3'(b);
      end
    end
    byte_v = map_rd_r[{byte_sel, 3'd0} +: 8];
    kk = '0;
    for (int k = 0; k < 8; k++) begin
      if (!byte_v[k]) begin
        kk = 3'(k);
      end
    end
  end

  always_comb begin
    pos     = is_alloc ? {byte_sel, kk} : bit_r;
    old_bit = map_rd_r[pos];
    set_bit = !rel_r;
    changed = is_alloc || (rel_r ? old_bit : !old_bit);
    map_new = map_rd_r;
    map_new[pos] = set_bit;
    l1_new  = l1_rd_r;
    l1_new[waddr_r[GADDR_W-1:0]] = &map_new;
    grant   = is_alloc ? {waddr_r, pos} : '0;
    if (!changed) begin
      count_new = free_r;
    end else if (set_bit) begin
      count_new = (free_r != '0) ? free_r - 1'b1 : free_r;
    end else begin
      count_new = (free_r != CNT_MAX) ? free_r + 1'b1 : free_r;
    end
  end

  always_comb begin
    for (int k = 0; k < GRP_N; k++) begin
      l1_init[k] = word_full_init({clr_cnt_r[GADDR_W-1:0], GADDR_W'(k)});
    end
  end

  // Next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    rd_map    = 1'b0;
    rd_l1     = 1'b0;
    commit    = 1'b0;
    out_load  = 1'b0;
    map_raddr = in_tdata[BLK_W-1:BIT_W];
    l1_raddr  = in_tdata[BLK_W-1:BLK_W-GADDR_W];
    waddr_nxt = waddr_r;
    bit_nxt   = bit_r;
    rel_nxt   = rel_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_tuser) inside
            OP_ALLOC: begin
              rel_nxt = 1'b0;
              if (&l2_r) begin
                res_nxt   = ST_FULL;
                state_nxt = S_PUT;
              end else begin
                l1_raddr  = grp_sel;
                rd_l1     = 1'b1;
                waddr_nxt = {grp_sel, GADDR_W'(0)};
                state_nxt = S_ALOC_L1;
              end
            end
            OP_RELEASE, OP_MARK: begin
              if (!in_range || (in_tuser == OP_RELEASE && in_tdata == '0)) begin
                res_nxt   = ST_NOCHG;
                state_nxt = S_PUT;
              end else begin
                rd_l1     = 1'b1;
                rd_map    = 1'b1;
                waddr_nxt = in_tdata[BLK_W-1:BIT_W];
                bit_nxt   = in_tdata[BIT_W-1:0];
                rel_nxt   = (in_tuser == OP_RELEASE);
                state_nxt = S_UPD;
              end
            end
            default: begin
              res_nxt   = ST_NOCHG;
              state_nxt = S_PUT;
            end
          endcase
        end
      end
      S_ALOC_L1: begin
        map_raddr = {waddr_r[WADDR_W-1:GADDR_W], wsel};
        rd_map    = 1'b1;
        waddr_nxt = map_raddr;
        state_nxt = S_ALOC_MAP;
      end
      S_ALOC_MAP, S_UPD: begin
        if (out_free) begin
          commit    = 1'b1;
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      free_r      <= FREE_INIT;
      for (int g = 0; g < GRP_N; g++) begin
        l2_r[g] <= grp_full_init(GADDR_W'(g));
      end
    end else begin
      if (clr_we) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (commit && changed) begin
        free_r <= count_new;
        l2_r[waddr_r[WADDR_W-1:GADDR_W]] <= &l1_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    waddr_r <= waddr_nxt;
    bit_r   <= bit_nxt;
    rel_r   <= rel_nxt;
    res_r   <= res_nxt;
    if (out_load) begin
      out_grant_r  <= commit ? grant : '0;
      out_status_r <= commit ? (changed ? ST_DONE : ST_NOCHG) : res_r;
      out_count_r  <= commit ? count_new : free_r;
    end
  end

  // Map and L1 memories: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (clr_we) begin
      map_mem[clr_cnt_r] <= word_init(clr_cnt_r);
      if (clr_cnt_r[WADDR_W-1:GADDR_W] == '0) begin
        l1_mem[clr_cnt_r[GADDR_W-1:0]] <= l1_init;
      end
    end else if (commit && changed) begin
      map_mem[waddr_r] <= map_new;
      l1_mem[waddr_r[WADDR_W-1:GADDR_W]] <= l1_new;
    end
    if (rd_map) begin
      map_rd_r <= map_mem[map_raddr];
    end
    if (rd_l1) begin
      l1_rd_r <= l1_mem[l1_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_count_r, out_grant_r};
  assign out_tuser  = out_status_r;

  // Clearing pass must hold off requests.
  a_clear_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("request accepted during clearing pass");

  // Summaries led the search to a word that has a free bit.
  a_alloc_word_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALOC_MAP) |-> !(&map_rd_r))
    else $error("allocate reached a full map word");

  a_full_grants_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_FULL) |-> (out_tdata[15:0] == '0))
    else $error("full status with nonzero grant");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FREE_INIT)
    else $error("free count above disk size");

endmodule
